>>> rtl/core/huffman_stream_encoder_macros.svh
// Assertion macros for the huffman stream encoder.
// No dependencies; included by files that carry concurrent assertions.
`ifndef HUFFMAN_STREAM_ENCODER_MACROS_SVH
`define HUFFMAN_STREAM_ENCODER_MACROS_SVH

// Check a property on an explicit clock, disabled while reset is high.
`define HSE_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check on the block's own clock and reset.
`define HSE_ASSERT(label, prop, msg) \
   `HSE_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

>>> rtl/core/hse_pkg.sv
// Shared types and constants of the huffman stream encoder.
// No dependencies; imported by hse_packer and huffman_stream_encoder.
package hse_pkg;

   localparam int BYTE_W  = 8;
   localparam int SYM_W   = 8;
   localparam int OP_W    = 2;
   localparam int CODE_W  = 32;
   localparam int LEN_W   = 6;
   localparam int PEND_W  = 7;
   localparam int CNT_W   = 3;
   localparam int ACC_W   = CODE_W + PEND_W;
   localparam int RUN_W   = 3;
   localparam int POS_W   = 6;

   localparam int DEF_MAX_CODE_LEN = 32;
   localparam int DEF_SYMBOL_COUNT = 256;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } opcode_type;

   // Execute-stage control handed from the front end to the packer
   typedef struct packed {
      logic valid;   // an encode or flush waits in the execute stage
      logic flush;   // flush, else encode
      logic len_ok;  // length entry was written since reset
   } exec_ctl_type;

endpackage

>>> rtl/core/huffman_stream_encoder.sv
// Huffman stream encoder for byte symbols. Each request beat carries an
// opcode: load writes one entry of the code table (code word plus length,
// lengths above MAX_CODE_LEN or 32 saturate), encode appends the symbol's
// code bits to a bit packer and emits every completed byte MSB-first, and
// flush zero-pads the pending bits, if any, to a byte, emits it with
// end_of_stream set and clears the packer. A symbol whose length is zero
// (including one never loaded) and a symbol at or beyond SYMBOL_COUNT emit
// nothing; opcode 3 is dropped. Throughput is one request per cycle while
// the execute stage does not stall: the code and length stores sit in RAMs
// read on acceptance, so an encode reaches the packer in the next cycle,
// and the packer's output register drains one byte per beat. An item that
// yields k bytes (at most four) holds the output until all k are taken, and
// a following item that also yields bytes waits in the execute stage until
// the last of them is being taken; items that yield nothing never wait on
// the output, and loads wait only behind a stalled item. The length store's
// per-entry valid flags clear at reset, so no clearing pass is run.
// Depends on hse_pkg, hse_ram, hse_packer and the assertion macro header.
`include "huffman_stream_encoder_macros.svh"

module huffman_stream_encoder
   import hse_pkg::*;
#(
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
   parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [SYM_W-1:0]   req_symbol,
   input  logic [CODE_W-1:0]  req_code_word,
   input  logic [LEN_W-1:0]   req_code_length,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_last_of_run,
   output logic               rsp_end_of_stream
);

   localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
   localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

   logic               req_accept;
   logic               in_range;
   logic               is_load, is_encode, is_flush;
   logic [ADDR_W-1:0]  tbl_addr;
   logic               wr_en, rd_en;
   logic [LEN_W-1:0]   sat_len;
   logic [CODE_W-1:0]  code_rd;
   logic [LEN_W-1:0]   len_rd;
   logic               ex_take;

   logic [SYMBOL_COUNT-1:0] len_valid_ff, len_valid_in;
   exec_ctl_type            ex_ctl_ff, ex_ctl_in;

   // ---------------------------------------------------------------
   // Front end: decode the request beat, address the table stores
   // ---------------------------------------------------------------
   always_comb begin
      req_accept = req_valid && req_ready;
      in_range   = {1'b0, req_symbol} < (SYM_W+1)'(SYMBOL_COUNT);
      is_load    = (req_opcode == OP_LOAD);
      is_encode  = (req_opcode == OP_ENCODE);
      is_flush   = (req_opcode == OP_FLUSH);
      tbl_addr   = req_symbol[ADDR_W-1:0];
      // saturate the loaded length to the table's cap
      sat_len    = (req_code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                       : req_code_length;
      wr_en      = req_accept && is_load && in_range;
      rd_en      = req_accept && is_encode && in_range;
   end

   // Accept whenever the execute stage is empty or moves on this cycle
   assign req_ready = !ex_ctl_ff.valid || ex_take;

   // Mark a length entry written; unwritten entries read as zero length
   always_comb begin
      len_valid_in = len_valid_ff;
      if (wr_en) begin
         len_valid_in[tbl_addr] = 1'b1;
      end
   end

   // Advance an encode or flush into the execute stage; loads end here
   always_comb begin
      ex_ctl_in = ex_ctl_ff;
      if (req_ready) begin
         ex_ctl_in.valid  = req_accept && ((is_encode && in_range) || is_flush);
         ex_ctl_in.flush  = is_flush;
         ex_ctl_in.len_ok = len_valid_ff[tbl_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_valid_ff <= '0;
         ex_ctl_ff    <= '0;
      end else begin
         len_valid_ff <= len_valid_in;
         ex_ctl_ff    <= ex_ctl_in;
      end
   end

   // ---------------------------------------------------------------
   // Table stores: written by loads, read when an encode is accepted.
   // A load and an encode never share a cycle, so the read always sees
   // every earlier load.
   // ---------------------------------------------------------------
   hse_ram #(
      .WIDTH (CODE_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_code_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tbl_addr),
      .wr_data (req_code_word),
      .rd_en   (rd_en),
      .rd_addr (tbl_addr),
      .rd_data (code_rd)
   );

   hse_ram #(
      .WIDTH (LEN_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tbl_addr),
      .wr_data (sat_len),
      .rd_en   (rd_en),
      .rd_addr (tbl_addr),
      .rd_data (len_rd)
   );

   // ---------------------------------------------------------------
   // Execute stage: pack bits, drain bytes through the output register
   // ---------------------------------------------------------------
   hse_packer u_packer (
      .clock             (clock),
      .reset             (reset),
      .ex_ctl            (ex_ctl_ff),
      .ex_code           (code_rd),
      .ex_len            (len_rd),
      .ex_take           (ex_take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `HSE_ASSERT(a_stall_blocks_req,
      (ex_ctl_ff.valid && !ex_take) |-> !req_ready, "request accepted during stall")
   `HSE_ASSERT(a_load_marks_valid,
      wr_en |=> len_valid_ff[$past(tbl_addr)], "loaded length entry not marked valid")
   `HSE_ASSERT(a_eos_is_last,
      (rsp_valid && rsp_end_of_stream) |-> rsp_last_of_run, "flush byte not last of run")
   `HSE_ASSERT(a_take_moves_stage,
      (ex_take && !req_accept) |=> !ex_ctl_ff.valid, "execute stage kept a handed-on item")

endmodule

>>> rtl/core/hse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the code and length stores.
module hse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/hse_packer.sv
// Bit packer and byte emitter of the huffman stream encoder.
// Depends on hse_pkg; instantiated by huffman_stream_encoder.
module hse_packer
   import hse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  exec_ctl_type       ex_ctl,
   input  logic [CODE_W-1:0]  ex_code,
   input  logic [LEN_W-1:0]   ex_len,
   output logic               ex_take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_last_of_run,
   output logic               rsp_end_of_stream
);

   logic [PEND_W-1:0] pend_bits_ff, pend_bits_in;
   logic [CNT_W-1:0]  pend_cnt_ff, pend_cnt_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  tail_ff, tail_in;
   logic              eos_ff, eos_in;

   logic [LEN_W-1:0]  len_eff;
   logic [ACC_W-1:0]  code_mask;
   logic [ACC_W-1:0]  enc_acc;
   logic [POS_W-1:0]  enc_total;
   logic [CNT_W-1:0]  enc_rem;
   logic [BYTE_W-1:0] pad_byte;
   logic [RUN_W-1:0]  res_cnt;
   logic              emit_free;
   logic [POS_W-1:0]  pos;
   logic [ACC_W-1:0]  acc_shift;

   // Append the code bits below the pending bits
   always_comb begin
      len_eff   = ex_ctl.len_ok ? ex_len : '0;
      code_mask = ~({ACC_W{1'b1}} << len_eff);
      enc_acc   = ({{(ACC_W-PEND_W){1'b0}}, pend_bits_ff} << len_eff)
                | ({{(ACC_W-CODE_W){1'b0}}, ex_code} & code_mask);
      enc_total = {{(POS_W-CNT_W){1'b0}}, pend_cnt_ff} + len_eff;
      enc_rem   = enc_total[CNT_W-1:0];
      pad_byte  = BYTE_W'({1'b0, pend_bits_ff} << (4'(BYTE_W) - {1'b0, pend_cnt_ff}));
      if (ex_ctl.flush) begin
         res_cnt = (pend_cnt_ff != '0) ? RUN_W'(1) : '0;
      end else begin
         res_cnt = enc_total[POS_W-1:CNT_W];
      end
      emit_free = (run_ff == '0) || ((run_ff == RUN_W'(1)) && rsp_ready);
      ex_take   = ex_ctl.valid && ((res_cnt == '0) || emit_free);
   end

   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      run_in       = run_ff;
      acc_in       = acc_ff;
      tail_in      = tail_ff;
      eos_in       = eos_ff;
      if (rsp_valid && rsp_ready) begin
         run_in = run_ff - RUN_W'(1);
      end
      if (ex_take) begin
         if (ex_ctl.flush) begin
            pend_bits_in = '0;
            pend_cnt_in  = '0;
         end else begin
            pend_bits_in = enc_acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << enc_rem);
            pend_cnt_in  = enc_rem;
         end
         // load the next burst once the previous one drains; an item that
         // yields no byte leaves a draining burst alone
         if (res_cnt != '0) begin
            run_in  = res_cnt;
            acc_in  = ex_ctl.flush ? {{(ACC_W-BYTE_W){1'b0}}, pad_byte} : enc_acc;
            tail_in = ex_ctl.flush ? '0 : enc_rem;
            eos_in  = ex_ctl.flush;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         run_ff       <= '0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         run_ff       <= run_in;
      end
      acc_ff  <= acc_in;
      tail_ff <= tail_in;
      eos_ff  <= eos_in;
   end

   // Earliest byte sits highest; each beat walks down by one byte
   always_comb begin
      pos       = {run_ff - RUN_W'(1), tail_ff};
      acc_shift = acc_ff >> pos;
   end

   assign rsp_valid         = (run_ff != '0);
   assign rsp_out_byte      = acc_shift[BYTE_W-1:0];
   assign rsp_last_of_run   = (run_ff == RUN_W'(1));
   assign rsp_end_of_stream = eos_ff;

endmodule

>>> dv/huffman_stream_encoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for huffman_stream_encoder: code table loads, encodes, flushes.
// Depends on hse_pkg and the encoder RTL; expected bytes come from a packer model kept here.
module huffman_stream_encoder_test;
   import hse_pkg::*;

   // Opcode 3 has no enum member; the block must drop it.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int LEN_LIMIT = (DEF_MAX_CODE_LEN < CODE_W) ? DEF_MAX_CODE_LEN : CODE_W;
   localparam int RX_LONG_HOLD = 200;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              eos;
   } out_beat_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [OP_W-1:0]   req_opcode;
   logic [SYM_W-1:0]  req_symbol;
   logic [CODE_W-1:0] req_code_word;
   logic [LEN_W-1:0]  req_code_length;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BYTE_W-1:0] rsp_out_byte;
   logic              rsp_last_of_run;
   logic              rsp_end_of_stream;

   // Model of the code table and the bit packer
   logic [CODE_W-1:0] code_table [256];
   logic [LEN_W-1:0]  len_table [256];
   bit                code_loaded [256];
   logic [PEND_W-1:0] packer_bits;
   logic [CNT_W-1:0]  packer_count;

   out_beat_type expected_bytes_q [$];
   int           error_count;

   // Idle controls for both sides of the block
   bit tx_idle_on;
   bit rx_idle_on;
   int rx_hold_cycles;
   int rx_wait;
   bit rx_taken;

   huffman_stream_encoder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_symbol        (req_symbol),
      .req_code_word     (req_code_word),
      .req_code_length   (req_code_length),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_end_of_stream (rsp_end_of_stream)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   // Apply one accepted beat to the packer model and queue the bytes it yields.
   task automatic predict_packed_bytes(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                       input logic [CODE_W-1:0] word,
                                       input logic [LEN_W-1:0] len);
      logic [63:0]  acc;
      logic [63:0]  mask;
      int           n;
      int           total;
      int           nbytes;
      out_beat_type beat;
      case (op)
         OP_LOAD: begin
            code_table[sym]  = word;
            len_table[sym]   = (len > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : len;
            code_loaded[sym] = 1'b1;
         end
         OP_ENCODE: begin
            n = int'(len_table[sym]);
            if (n != 0) begin
               mask   = (64'd1 << n) - 64'd1;
               acc    = ({57'd0, packer_bits} << n) | ({32'd0, code_table[sym]} & mask);
               total  = int'(packer_count) + n;
               nbytes = total / BYTE_W;
               for (int i = 0; i < nbytes; i++) begin
                  total     -= BYTE_W;
                  beat.data  = BYTE_W'(acc >> total);
                  beat.last  = (i == nbytes - 1);
                  beat.eos   = 1'b0;
                  expected_bytes_q.push_back(beat);
               end
               packer_count = CNT_W'(total);
               packer_bits  = PEND_W'(acc & ((64'd1 << total) - 64'd1));
            end
         end
         OP_FLUSH: begin
            // Nothing pending: no pad byte at all
            if (packer_count != 0) begin
               beat.data = BYTE_W'({1'b0, packer_bits} << (BYTE_W - int'(packer_count)));
               beat.last = 1'b1;
               beat.eos  = 1'b1;
               expected_bytes_q.push_back(beat);
               packer_bits  = '0;
               packer_count = '0;
            end
         end
         default: ;
      endcase
   endtask

   // Offer one request beat after a random gap, hold it until accepted, then predict.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] word, input logic [LEN_W-1:0] len);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 19) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_symbol      <= sym;
      req_code_word   <= word;
      req_code_length <= len;
      do @(posedge clock); while (!req_ready);
      predict_packed_bytes(op, sym, word, len);
   endtask

   // Drop valid and hold off until every queued byte has been seen.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [SYM_W-1:0] pick_loaded_symbol();
      logic [SYM_W-1:0] sym;
      for (int tries = 0; tries < 16; tries++) begin
         sym = SYM_W'($urandom_range(0, 255));
         if (code_loaded[sym]) return sym;
      end
      return '0;
   endfunction

   // Check each result beat against the oldest expected byte
   always @(posedge clock) begin
      out_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rx_taken = 1'b1;
         if (expected_bytes_q.size() == 0) begin
            report_mismatch("unexpected byte", 32'(rsp_out_byte), 32'd0);
         end else begin
            want = expected_bytes_q.pop_front();
            if (rsp_out_byte !== want.data)
               report_mismatch("out_byte", 32'(rsp_out_byte), 32'(want.data));
            if (rsp_last_of_run !== want.last)
               report_mismatch("last_of_run", 32'(rsp_last_of_run), 32'(want.last));
            if (rsp_end_of_stream !== want.eos)
               report_mismatch("end_of_stream", 32'(rsp_end_of_stream), 32'(want.eos));
         end
      end
   end

   // Receiver: draw a fresh wait after every taken byte; a long hold overrides it.
   always @(negedge clock) begin
      if (rx_hold_cycles > 0) begin
         rx_hold_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_taken) begin
            rx_taken = 1'b0;
            rx_wait  = rx_idle_on ? $urandom_range(0, 19) : 0;
         end
         if (rx_wait > 0) begin
            rx_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Extremes of every field, each opcode, saturation, zero length and empty flushes.
   task automatic test_directed_cases();
      send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);             // flush on an empty packer
      send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);   // drop the unused opcode
      send_item(OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd63);     // saturate the length to 32
      send_item(OP_LOAD, 8'hFF, 32'h0000_0000, 6'd32);
      send_item(OP_LOAD, 8'h55, 32'h0000_0001, 6'd1);
      send_item(OP_LOAD, 8'hAA, 32'hDEAD_BEEF, 6'd0);      // zero length: encode emits nothing
      send_item(OP_LOAD, 8'h80, 32'h0000_005A, 6'd7);
      send_item(OP_LOAD, 8'h01, 32'h5A5A_00A5, 6'd33);     // just above the limit
      send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);
      send_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
      send_item(OP_ENCODE, 8'h55, 32'h0, 6'd0);
      send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);             // pad a single bit
      send_item(OP_ENCODE, 8'hAA, 32'h0, 6'd0);
      send_item(OP_ENCODE, 8'h80, 32'h0, 6'd0);
      send_item(OP_ENCODE, 8'h55, 32'h0, 6'd0);
      send_item(OP_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'd63);   // encode ignores word and length
      send_item(OP_ENCODE, 8'h80, 32'h0, 6'd0);
      send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);            // seven pending plus 32: four bytes
      send_item(OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
      send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
      send_item(OP_UNUSED, 8'h00, 32'h0, 6'd0);
      wait_drained();
   endtask

   // Stall the receiver for a long stretch while long codes stream in back to back.
   task automatic test_output_backpressure();
      send_item(OP_LOAD, 8'h3C, $urandom, 6'd32);
      send_item(OP_LOAD, 8'hC3, $urandom, 6'd29);
      wait_drained();
      tx_idle_on     = 1'b0;
      rx_hold_cycles = RX_LONG_HOLD;
      for (int i = 0; i < 24; i++)
         send_item(OP_ENCODE, (i % 3 == 0) ? 8'hC3 : 8'h3C, 32'h0, 6'd0);
      send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
      wait_drained();
   endtask

   // Burst, then pause the sender until every byte is out, then burst again.
   task automatic test_sender_pause();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b1;
      for (int burst = 0; burst < 3; burst++) begin
         for (int i = 0; i < 8; i++)
            send_item(OP_ENCODE, pick_loaded_symbol(), $urandom, 6'($urandom));
         wait_drained();
      end
   endtask

   // Mostly well-formed encode streams over a changing table, plus flushes and noise.
   task automatic test_random_stream();
      int               done;
      int               pick;
      logic [SYM_W-1:0] sym;
      logic [LEN_W-1:0] len;
      done = 0;
      while (done < 320) begin
         if (done % 40 == 0) begin
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
         end
         pick = $urandom_range(0, 99);
         sym  = SYM_W'($urandom_range(0, 255));
         if (pick < 4) begin
            send_item(OP_UNUSED, sym, $urandom, 6'($urandom));
         end else if (pick < 20 || !code_loaded[sym]) begin
            case ($urandom_range(0, 9))
               0:       len = 6'($urandom_range(33, 63));
               1:       len = 6'd0;
               2, 3:    len = 6'($urandom_range(1, 32));
               default: len = 6'($urandom_range(1, 12));
            endcase
            send_item(OP_LOAD, sym, $urandom, len);
            done++;
         end else if (pick < 28) begin
            send_item(OP_FLUSH, sym, $urandom, 6'($urandom));
            done++;
         end else begin
            send_item(OP_ENCODE, sym, $urandom, 6'($urandom));
            done++;
         end
      end
      send_item(OP_FLUSH, 8'h00, 32'h0, 6'd0);
      wait_drained();
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_LOAD;
      req_symbol      = '0;
      req_code_word   = '0;
      req_code_length = '0;
      rsp_ready       = 1'b0;
      error_count     = 0;
      tx_idle_on      = 1'b1;
      rx_idle_on      = 1'b1;
      rx_hold_cycles  = 0;
      rx_wait         = 0;
      rx_taken        = 1'b0;
      packer_bits     = '0;
      packer_count    = '0;
      for (int i = 0; i < 256; i++) begin
         code_table[i]  = '0;
         len_table[i]   = '0;
         code_loaded[i] = 1'b0;
      end
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_output_backpressure();
      test_sender_pause();
      test_random_stream();

      // Let any stray byte surface before the verdict
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_bytes_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
